[hw/rtl/gmft_pkg.sv]
// ----------------------------------------------------------------------------
// gmft_pkg
// Shared types and constants of the geared motor feedback tracker.
// ----------------------------------------------------------------------------
package gmft_pkg;

    localparam int ANGLE_W    = 16;
    localparam int COUNT_W    = 40;
    localparam int SLOT_ID_W  = 3;
    localparam int TYPE_BITS  = 6;
    localparam int MASK_W     = 1 << SLOT_ID_W;
    localparam int ENTRY_W    = 2 * ANGLE_W + COUNT_W;
    localparam int STEP_W     = ANGLE_W + 2;
    localparam int ID_W       = 11;
    localparam int POS_SCALE_W = 24;
    localparam int SPD_SCALE_W = 32;
    localparam int SPEED_OUT_W = 32;
    localparam int POS_OUT_W   = 48;
    localparam int FRAC_W      = 16;
    localparam int FIFO0_SLOTS = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_SCALE_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_SCALE_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE_B = 3'd5;

    localparam logic [ID_W-1:0]        RST_ID_BASE       = 11'd513;
    localparam logic [TYPE_BITS-1:0]   RST_TYPE_MASK     = 6'd19;
    localparam logic [POS_SCALE_W-1:0] RST_POS_SCALE_A   = 24'd9933878;
    localparam logic [POS_SCALE_W-1:0] RST_POS_SCALE_B   = 24'd5242880;
    localparam logic [SPD_SCALE_W-1:0] RST_SPEED_SCALE_A = 32'd226050910;
    localparam logic [SPD_SCALE_W-1:0] RST_SPEED_SCALE_B = 32'd119304647;

    localparam logic signed [STEP_W-1:0] WRAP_LIMIT = 18'sd4000;
    localparam logic signed [STEP_W-1:0] TURN_STEPS = 18'sd8192;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    typedef struct packed {
        logic                      rx_fifo;
        logic                      is_extended;
        logic [ID_W-1:0]           std_id;
        logic [ANGLE_W-1:0]        angle_word;
        logic signed [15:0]        speed_word;
        logic signed [15:0]        current_word;
    } t_in_item;

    typedef struct packed {
        logic                          handled;
        logic                          forward_extended;
        logic [SLOT_ID_W-1:0]          motor_slot;
        logic signed [15:0]            current_raw;
        logic signed [SPEED_OUT_W-1:0] speed_q16;
        logic signed [POS_OUT_W-1:0]   position_q16;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]        id_base;
        logic [TYPE_BITS-1:0]   type_mask;
        logic [POS_SCALE_W-1:0] pos_scale_a;
        logic [POS_SCALE_W-1:0] pos_scale_b;
        logic [SPD_SCALE_W-1:0] speed_scale_a;
        logic [SPD_SCALE_W-1:0] speed_scale_b;
    } t_cfg;

    typedef struct packed {
        logic                 handled;
        logic                 ext;
        logic [SLOT_ID_W-1:0] slot;
        logic signed [15:0]   current;
    } t_ctrl;

    typedef struct packed {
        t_ctrl                     ctrl;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [15:0]        speed;
    } t_s1;

    typedef struct packed {
        t_ctrl                     ctrl;
        logic signed [COUNT_W-1:0] cnt;
        logic signed [15:0]        speed;
        logic [POS_SCALE_W-1:0]    ps;
        logic [SPD_SCALE_W-1:0]    ss;
    } t_s2;

endpackage

[hw/rtl/gmft_ram.sv]
// ----------------------------------------------------------------------------
// gmft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/gmft_unwrap.sv]
// ----------------------------------------------------------------------------
// gmft_unwrap
// Slot state memory with read-modify-write: angle unwrap and turn count.
// ----------------------------------------------------------------------------
module gmft_unwrap import gmft_pkg::*; #(
    parameter int MOTOR_SLOTS = 6,
    parameter int SLOT_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_acc,
    input  logic              i_hit,
    input  logic [SLOT_W-1:0] i_raddr,
    input  t_s1               i_s1,
    input  t_cfg              i_cfg,
    output logic              o_v2,
    output t_s2               o_s2
);

    logic                     r_v1;
    t_s1                      r_s1;
    logic                     r_v2;
    t_s2                      r_s2;
    logic [MOTOR_SLOTS-1:0]   r_ent_valid;
    logic                     r_last_valid;
    logic [SLOT_W-1:0]        r_last_slot;
    logic [ENTRY_W-1:0]       r_last_data;

    logic [ENTRY_W-1:0]        rdata;
    logic [ENTRY_W-1:0]        cur_entry;
    logic [ENTRY_W-1:0]        new_entry;
    logic [SLOT_W-1:0]         idx;
    logic signed [ANGLE_W-1:0] old_prev;
    logic signed [ANGLE_W-1:0] old_now;
    logic signed [COUNT_W-1:0] old_cnt;
    logic                      zero_init;
    logic signed [ANGLE_W:0]   step_raw;
    logic signed [STEP_W-1:0]  step_ext;
    logic signed [STEP_W-1:0]  step_w;
    logic signed [COUNT_W:0]   cnt_sum;
    logic signed [COUNT_W-1:0] new_cnt;
    logic signed [ANGLE_W-1:0] new_prev;
    logic [MASK_W-1:0]         mask8;
    logic                      geared19;
    logic                      we;

    gmft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MOTOR_SLOTS),
        .ADDR_W(SLOT_W)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(idx),
        .i_wdata(new_entry),
        .i_re   (i_acc & i_hit),
        .i_raddr(i_raddr),
        .o_rdata(rdata)
    );

    assign idx = r_s1.ctrl.slot[SLOT_W-1:0];

    // latest write wins over the ram read, untouched entries read as zero
    always_comb begin
        if (r_last_valid && (r_last_slot == idx)) begin
            cur_entry = r_last_data;
        end else if (!r_ent_valid[idx]) begin
            cur_entry = '0;
        end else begin
            cur_entry = rdata;
        end
    end

    assign {old_prev, old_now, old_cnt} = cur_entry;
    assign zero_init = (old_prev == '0) && (old_now == '0);
    assign new_prev  = zero_init ? r_s1.angle : old_now;
    assign step_raw  = zero_init ? '0 :
                       $signed({r_s1.angle[ANGLE_W-1], r_s1.angle})
                       - $signed({old_now[ANGLE_W-1], old_now});
    assign step_ext  = $signed({step_raw[ANGLE_W], step_raw});

    always_comb begin
        if (step_ext > WRAP_LIMIT) begin
            step_w = step_ext - TURN_STEPS;
        end else if (step_ext < -WRAP_LIMIT) begin
            step_w = step_ext + TURN_STEPS;
        end else begin
            step_w = step_ext;
        end
    end

    assign cnt_sum = $signed({old_cnt[COUNT_W-1], old_cnt})
                     + $signed({{(COUNT_W+1-STEP_W){step_w[STEP_W-1]}}, step_w});

    always_comb begin
        if (cnt_sum[COUNT_W] != cnt_sum[COUNT_W-1]) begin
            new_cnt = cnt_sum[COUNT_W] ? COUNT_MIN : COUNT_MAX;
        end else begin
            new_cnt = cnt_sum[COUNT_W-1:0];
        end
    end

    assign new_entry = {new_prev, r_s1.angle, new_cnt};
    assign we        = r_v1 && r_s1.ctrl.handled && i_en;
    assign mask8     = {{(MASK_W-TYPE_BITS){1'b0}}, i_cfg.type_mask};
    assign geared19  = mask8[r_s1.ctrl.slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_ent_valid  <= '0;
            r_last_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_v1 <= i_acc;
                r_v2 <= r_v1;
            end
            if (we) begin
                r_ent_valid[idx] <= 1'b1;
                r_last_valid     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1 <= i_s1;
        end
        if (we) begin
            r_last_slot <= idx;
            r_last_data <= new_entry;
        end
        if (i_en && r_v1) begin
            r_s2.ctrl  <= r_s1.ctrl;
            r_s2.cnt   <= r_s1.ctrl.handled ? new_cnt : '0;
            r_s2.speed <= r_s1.speed;
            r_s2.ps    <= geared19 ? i_cfg.pos_scale_a : i_cfg.pos_scale_b;
            r_s2.ss    <= geared19 ? i_cfg.speed_scale_a : i_cfg.speed_scale_b;
        end
    end

    assign o_v2 = r_v2;
    assign o_s2 = r_s2;

`ifndef SYNTH
    a_write_marks_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_ent_valid[$past(idx)])
        else $error("written entry not marked valid");

    a_forward_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_valid |-> r_ent_valid[r_last_slot])
        else $error("forwarded entry not marked valid");

    a_no_write_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |-> !we)
        else $error("state written while pipeline held");
`endif

endmodule

[hw/rtl/gmft_scale.sv]
// ----------------------------------------------------------------------------
// gmft_scale
// Speed and position scaling: magnitude, split multiply, round, saturate.
// ----------------------------------------------------------------------------
module gmft_scale import gmft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_v2,
    input  t_s2       i_s2,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int HALF_W = COUNT_W / 2;
    localparam int PP_W   = HALF_W + POS_SCALE_W;
    localparam int SP_W   = 16 + SPD_SCALE_W;
    localparam int FULL_W = COUNT_W + POS_SCALE_W;
    localparam logic [POS_OUT_W-1:0]   POS_LIM = {1'b1, {(POS_OUT_W-1){1'b0}}};
    localparam logic [SPEED_OUT_W-1:0] SPD_LIM = {1'b1, {(SPEED_OUT_W-1){1'b0}}};

    typedef struct packed {
        t_ctrl                  ctrl;
        logic                   c_neg;
        logic [COUNT_W-1:0]     c_mag;
        logic                   s_neg;
        logic [15:0]            s_mag;
        logic [POS_SCALE_W-1:0] ps;
        logic [SPD_SCALE_W-1:0] ss;
    } t_s3;

    typedef struct packed {
        t_ctrl           ctrl;
        logic            c_neg;
        logic            s_neg;
        logic [PP_W-1:0] pp_lo;
        logic [PP_W-1:0] pp_hi;
        logic [SP_W-1:0] sp;
    } t_s4;

    typedef struct packed {
        t_ctrl                  ctrl;
        logic                   c_neg;
        logic                   s_neg;
        logic [POS_OUT_W-1:0]   c_sh;
        logic [SPEED_OUT_W-1:0] s_sh;
    } t_s5;

    logic      r_v3, r_v4, r_v5, r_out_valid;
    t_s3       r_s3;
    t_s4       r_s4;
    t_s5       r_s5;
    t_out_item r_out;

    logic [FULL_W-1:0]      c_full;
    logic [SP_W-1:0]        s_full;
    logic [POS_OUT_W-1:0]   c_mag_sat;
    logic [SPEED_OUT_W-1:0] s_mag_sat;

    assign c_full = {r_s4.pp_hi, {HALF_W{1'b0}}} + FULL_W'(r_s4.pp_lo)
                    + FULL_W'(ROUND_HALF);
    assign s_full = r_s4.sp + SP_W'(ROUND_HALF);

    always_comb begin
        if (r_s5.c_neg) begin
            c_mag_sat = (r_s5.c_sh > POS_LIM) ? POS_LIM : r_s5.c_sh;
        end else begin
            c_mag_sat = r_s5.c_sh[POS_OUT_W-1] ? (POS_LIM - 1'b1) : r_s5.c_sh;
        end
        if (r_s5.s_neg) begin
            s_mag_sat = (r_s5.s_sh > SPD_LIM) ? SPD_LIM : r_s5.s_sh;
        end else begin
            s_mag_sat = r_s5.s_sh[SPEED_OUT_W-1] ? (SPD_LIM - 1'b1) : r_s5.s_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_v3        <= i_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3.ctrl  <= i_s2.ctrl;
            r_s3.c_neg <= i_s2.cnt[COUNT_W-1];
            r_s3.c_mag <= i_s2.cnt[COUNT_W-1] ? (~i_s2.cnt + 1'b1) : i_s2.cnt;
            r_s3.s_neg <= i_s2.speed[15];
            r_s3.s_mag <= i_s2.speed[15] ? (~i_s2.speed + 1'b1) : i_s2.speed;
            r_s3.ps    <= i_s2.ps;
            r_s3.ss    <= i_s2.ss;

            r_s4.ctrl  <= r_s3.ctrl;
            r_s4.c_neg <= r_s3.c_neg;
            r_s4.s_neg <= r_s3.s_neg;
            r_s4.pp_lo <= r_s3.c_mag[HALF_W-1:0] * r_s3.ps;
            r_s4.pp_hi <= r_s3.c_mag[COUNT_W-1:HALF_W] * r_s3.ps;
            r_s4.sp    <= r_s3.s_mag * r_s3.ss;

            r_s5.ctrl  <= r_s4.ctrl;
            r_s5.c_neg <= r_s4.c_neg;
            r_s5.s_neg <= r_s4.s_neg;
            r_s5.c_sh  <= c_full[FULL_W-1:FRAC_W];
            r_s5.s_sh  <= s_full[SP_W-1:FRAC_W];

            r_out.handled          <= r_s5.ctrl.handled;
            r_out.forward_extended <= r_s5.ctrl.ext;
            r_out.motor_slot       <= r_s5.ctrl.slot;
            r_out.current_raw      <= r_s5.ctrl.current;
            r_out.speed_q16        <= !r_s5.ctrl.handled ? '0 :
                                      r_s5.s_neg ? (~s_mag_sat + 1'b1) : s_mag_sat;
            r_out.position_q16     <= !r_s5.ctrl.handled ? '0 :
                                      r_s5.c_neg ? (~c_mag_sat + 1'b1) : c_mag_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef SYNTH
    a_handled_not_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.handled) |-> !r_out.forward_extended)
        else $error("item both handled and forwarded");

    a_unhandled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.handled) |->
        (r_out.position_q16 == '0 && r_out.speed_q16 == '0))
        else $error("unhandled item carries scaled values");
`endif

endmodule

[hw/rtl/geared_motor_feedback_tracker.sv]
// ----------------------------------------------------------------------------
// geared_motor_feedback_tracker
// Per-slot encoder unwrap and geared speed / position scaling of motor
// feedback frames.
// ----------------------------------------------------------------------------
// input channel i_valid / o_stall carries one feedback frame per item; the
// output channel o_valid / i_stall returns exactly one result item per frame.
// the user is to write the config port (i_cfg_we, i_cfg_index, i_cfg_data)
// only while idle; the block does not enforce this. results pass s1 to s5
// and a result register. throughput: one item per cycle unless the output
// stalls; the slot state ram is read at acceptance and written back from
// s1, a forward register covers a same-slot frame in the very next cycle.
// a stalled output holds its item and freezes the whole pipeline, so o_stall
// follows o_valid and i_stall; a result register sits between both sides.
// reset restores register defaults and empties the pipeline; per-slot valid
// flags make every slot read as zero state until its first frame, so no
// clearing pass is needed and items are taken right after reset.
// extended frames and unknown identifiers pass through with no state change.
// ----------------------------------------------------------------------------
module geared_motor_feedback_tracker import gmft_pkg::*; #(
    parameter int MOTOR_SLOTS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

    t_cfg          r_cfg;
    logic          en;
    logic          acc;
    logic [ID_W:0] diff;
    logic          in_range;
    logic          low_path;
    logic          hit;
    t_s1           s1;
    logic          v2;
    t_s2           s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_base       <= RST_ID_BASE;
            r_cfg.type_mask     <= RST_TYPE_MASK;
            r_cfg.pos_scale_a   <= RST_POS_SCALE_A;
            r_cfg.pos_scale_b   <= RST_POS_SCALE_B;
            r_cfg.speed_scale_a <= RST_SPEED_SCALE_A;
            r_cfg.speed_scale_b <= RST_SPEED_SCALE_B;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ID_BASE:       r_cfg.id_base       <= i_cfg_data[ID_W-1:0];
                CFG_TYPE_MASK:     r_cfg.type_mask     <= i_cfg_data[TYPE_BITS-1:0];
                CFG_POS_SCALE_A:   r_cfg.pos_scale_a   <= i_cfg_data[POS_SCALE_W-1:0];
                CFG_POS_SCALE_B:   r_cfg.pos_scale_b   <= i_cfg_data[POS_SCALE_W-1:0];
                CFG_SPEED_SCALE_A: r_cfg.speed_scale_a <= i_cfg_data[SPD_SCALE_W-1:0];
                CFG_SPEED_SCALE_B: r_cfg.speed_scale_b <= i_cfg_data[SPD_SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign acc     = i_valid && en;

    // slot decode
    assign diff     = {1'b0, i_item.std_id} - {1'b0, r_cfg.id_base};
    assign in_range = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(MOTOR_SLOTS));
    assign low_path = diff[ID_W-1:0] < ID_W'(FIFO0_SLOTS);
    assign hit      = !i_item.is_extended && in_range
                      && ((i_item.rx_fifo == 1'b0) == low_path);

    always_comb begin
        s1.ctrl.handled = hit;
        s1.ctrl.ext     = i_item.is_extended;
        s1.ctrl.slot    = hit ? diff[SLOT_ID_W-1:0] : '0;
        s1.ctrl.current = hit ? i_item.current_word : '0;
        s1.angle        = i_item.angle_word;
        s1.speed        = i_item.speed_word;
    end

    gmft_unwrap #(
        .MOTOR_SLOTS(MOTOR_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_unwrap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_acc  (acc),
        .i_hit  (hit),
        .i_raddr(diff[SLOT_W-1:0]),
        .i_s1   (s1),
        .i_cfg  (r_cfg),
        .o_v2   (v2),
        .o_s2   (s2)
    );

    gmft_scale u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v2   (v2),
        .i_s2   (s2),
        .o_valid(o_valid),
        .o_item (o_item)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geared motor feedback tracker testbench
// Sends feedback frames through the valid/stall input channel in random
// bursts while the result channel stalls on its own changing pattern. A
// scoreboard object carries its own copy of the registers and of the per-slot
// angle and turn-count state, predicts one result per accepted frame and
// checks every returned result field by field. Directed frames cover the
// wrap, first-sample, extended and unknown-identifier cases; random phases
// then run under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import gmft_pkg::*;

    localparam int MOTOR_SLOTS = 6;
    localparam longint COUNT_HI = 64'sd549755813887;
    localparam longint COUNT_LO = -COUNT_HI - 1;
    localparam int PHASE_ITEMS = 97;

    class feedback_tracker_sb;
        logic [ID_W-1:0]        id_base;
        logic [TYPE_BITS-1:0]   type_mask;
        logic [POS_SCALE_W-1:0] pos_scale_a;
        logic [POS_SCALE_W-1:0] pos_scale_b;
        logic [SPD_SCALE_W-1:0] speed_scale_a;
        logic [SPD_SCALE_W-1:0] speed_scale_b;
        shortint   prev_ang [MOTOR_SLOTS];
        shortint   now_ang [MOTOR_SLOTS];
        longint    turn_count [MOTOR_SLOTS];
        t_out_item pending_feedback [$];
        int        errors;

        function new();
            id_base       = RST_ID_BASE;
            type_mask     = RST_TYPE_MASK;
            pos_scale_a   = RST_POS_SCALE_A;
            pos_scale_b   = RST_POS_SCALE_B;
            speed_scale_a = RST_SPEED_SCALE_A;
            speed_scale_b = RST_SPEED_SCALE_B;
            foreach (prev_ang[s]) begin
                prev_ang[s]   = 0;
                now_ang[s]    = 0;
                turn_count[s] = 0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_ID_BASE:       id_base       = d[ID_W-1:0];
                CFG_TYPE_MASK:     type_mask     = d[TYPE_BITS-1:0];
                CFG_POS_SCALE_A:   pos_scale_a   = d[POS_SCALE_W-1:0];
                CFG_POS_SCALE_B:   pos_scale_b   = d[POS_SCALE_W-1:0];
                CFG_SPEED_SCALE_A: speed_scale_a = d;
                CFG_SPEED_SCALE_B: speed_scale_b = d;
                default: ;
            endcase
        endfunction

        // v * k / 2^16, round half away from zero, saturate to bits signed
        function longint scale_round(longint v, longint unsigned k, int bits);
            longint unsigned mag;
            longint unsigned lim;
            bit neg;
            neg = v < 0;
            mag = neg ? longint'(-v) : v;
            lim = 64'd1 << (bits - 1);
            mag = (mag * k + 64'd32768) >> FRAC_W;
            if (neg) begin
                if (mag > lim) mag = lim;
                return -longint'(mag);
            end
            if (mag > lim - 1) mag = lim - 1;
            return longint'(mag);
        endfunction

        function void note_frame(t_in_item f);
            t_out_item r;
            int slot;
            int step;
            shortint ang;
            longint cnt;
            longint unsigned ps;
            longint unsigned ss;
            longint spd;
            longint pos;
            r = '0;
            slot = int'(f.std_id) - int'(id_base);
            if (f.is_extended) begin
                r.forward_extended = 1'b1;
            end else if (slot >= 0 && slot < MOTOR_SLOTS &&
                         ((f.rx_fifo == 1'b0) == (slot < FIFO0_SLOTS))) begin
                ang = shortint'(f.angle_word);
                if (prev_ang[slot] == 0 && now_ang[slot] == 0) begin
                    prev_ang[slot] = ang;
                end else begin
                    prev_ang[slot] = now_ang[slot];
                end
                now_ang[slot] = ang;
                step = int'(now_ang[slot]) - int'(prev_ang[slot]);
                if (step > 4000) step -= 8192;
                else if (step < -4000) step += 8192;
                cnt = turn_count[slot] + step;
                if (cnt > COUNT_HI) cnt = COUNT_HI;
                if (cnt < COUNT_LO) cnt = COUNT_LO;
                turn_count[slot] = cnt;
                ps = 64'(type_mask[slot] ? pos_scale_a : pos_scale_b);
                ss = 64'(type_mask[slot] ? speed_scale_a : speed_scale_b);
                spd = scale_round(longint'(f.speed_word), ss, SPEED_OUT_W);
                pos = scale_round(cnt, ps, POS_OUT_W);
                r.handled      = 1'b1;
                r.motor_slot   = slot[SLOT_ID_W-1:0];
                r.current_raw  = f.current_word;
                r.speed_q16    = spd[SPEED_OUT_W-1:0];
                r.position_q16 = pos[POS_OUT_W-1:0];
            end
            pending_feedback.push_back(r);
        endfunction

        function void check_feedback(t_out_item got);
            t_out_item want;
            if (pending_feedback.size() == 0) begin
                $error("unexpected result item, slot %0d", got.motor_slot);
                errors++;
                return;
            end
            want = pending_feedback.pop_front();
            if (got.handled !== want.handled) begin
                $error("handled: expected %0d, got %0d", want.handled, got.handled);
                errors++;
            end
            if (got.forward_extended !== want.forward_extended) begin
                $error("forward_extended: expected %0d, got %0d",
                       want.forward_extended, got.forward_extended);
                errors++;
            end
            if (got.motor_slot !== want.motor_slot) begin
                $error("motor_slot: expected %0d, got %0d", want.motor_slot, got.motor_slot);
                errors++;
            end
            if (got.current_raw !== want.current_raw) begin
                $error("current_raw: expected %0d, got %0d",
                       want.current_raw, got.current_raw);
                errors++;
            end
            if (got.speed_q16 !== want.speed_q16) begin
                $error("speed_q16: expected %0d, got %0d", want.speed_q16, got.speed_q16);
                errors++;
            end
            if (got.position_q16 !== want.position_q16) begin
                $error("position_q16: expected %0d, got %0d",
                       want.position_q16, got.position_q16);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_item              i_item = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    feedback_tracker_sb sb;
    logic [15:0] trail_angle [MOTOR_SLOTS] = '{default: 16'd0};
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    geared_motor_feedback_tracker #(.MOTOR_SLOTS(MOTOR_SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL geared_motor_feedback_tracker");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_frame(i_item);
            if (o_valid && !i_stall) sb.check_feedback(o_item);
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((stall_left % 5) < 2);
        endcase
    end

    function automatic t_in_item frame_of(bit fifo, bit ext, int id, int ang, int spd,
                                          int cur);
        t_in_item f;
        f.rx_fifo      = fifo;
        f.is_extended  = ext;
        f.std_id       = ID_W'(id);
        f.angle_word   = 16'(ang);
        f.speed_word   = 16'(spd);
        f.current_word = 16'(cur);
        return f;
    endfunction

    function automatic t_in_item random_frame();
        t_in_item f;
        int pick;
        int slot;
        int top;
        int sel;
        int a;
        f.rx_fifo      = 1'($urandom);
        f.is_extended  = 1'b0;
        f.std_id       = ID_W'($urandom);
        f.angle_word   = 16'($urandom);
        f.speed_word   = 16'($urandom);
        f.current_word = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            f.speed_word = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 9) == 0)
            f.current_word = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        pick = $urandom_range(0, 99);
        if (pick < 72 || pick >= 92) begin
            top = 2047 - int'(sb.id_base);
            if (top > MOTOR_SLOTS - 1) top = MOTOR_SLOTS - 1;
            slot = $urandom_range(0, top);
            f.std_id = ID_W'(int'(sb.id_base) + slot);
            f.rx_fifo = (slot >= FIFO0_SLOTS);
            if (pick >= 92) begin
                f.rx_fifo = ~f.rx_fifo;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    a = (int'(trail_angle[slot]) + int'($urandom_range(0, 600)) - 300) & 8191;
                else if (sel < 70)
                    a = $urandom_range(0, 8191);
                else if (sel < 85)
                    a = (int'(trail_angle[slot]) + ($urandom_range(0, 1) ? 1 : -1) *
                         int'($urandom_range(3998, 4002))) & 8191;
                else if (sel < 92)
                    a = 0;
                else
                    a = $urandom_range(0, 65535);
                f.angle_word = 16'(a);
                trail_angle[slot] = f.angle_word;
            end
        end else if (pick < 82) begin
            f.is_extended = 1'b1;
        end
        return f;
    endfunction

    task automatic send_frame(input t_in_item f);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= f;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_feedback.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic set_config(input logic [31:0] base, input logic [31:0] mask,
                              input logic [31:0] pa, input logic [31:0] pb,
                              input logic [31:0] sa, input logic [31:0] sbv);
        write_reg(CFG_ID_BASE, base);
        write_reg(CFG_TYPE_MASK, mask);
        write_reg(CFG_POS_SCALE_A, pa);
        write_reg(CFG_POS_SCALE_B, pb);
        write_reg(CFG_SPEED_SCALE_A, sa);
        write_reg(CFG_SPEED_SCALE_B, sbv);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_run();
        repeat (PHASE_ITEMS) send_frame(random_frame());
        drain();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extended, unknown ids and wrong receive paths
        send_frame(frame_of(1, 1, 2047, 16'hffff, -1, -1));
        send_frame(frame_of(0, 0, 512, 100, 5, 5));
        send_frame(frame_of(1, 0, 519, 100, 5, 5));
        send_frame(frame_of(0, 0, 517, 100, 5, 5));
        send_frame(frame_of(1, 0, 514, 100, 5, 5));
        send_frame(frame_of(0, 0, 0, 100, 5, 5));
        // slot 0 wrap decisions around the limit
        send_frame(frame_of(0, 0, 513, 100, 32767, -32768));
        send_frame(frame_of(0, 0, 513, 8100, -32768, 32767));
        send_frame(frame_of(0, 0, 513, 50, 0, 0));
        send_frame(frame_of(0, 0, 513, 4050, 1, -1));
        send_frame(frame_of(0, 0, 513, 50, -1, 1));
        send_frame(frame_of(0, 0, 513, 4051, 1000, 7));
        send_frame(frame_of(0, 0, 513, 50, -1000, -7));
        // zero angle keeps reloading the first sample
        send_frame(frame_of(0, 0, 514, 0, 3, 3));
        send_frame(frame_of(0, 0, 514, 0, 3, 3));
        send_frame(frame_of(0, 0, 514, 8191, 3, 3));
        // full 16-bit angles on path 1, then first samples and a wrap on path 0
        send_frame(frame_of(1, 0, 518, 16'h8000, 0, 0));
        send_frame(frame_of(1, 0, 518, 16'h7fff, 32767, 32767));
        send_frame(frame_of(1, 0, 517, 16'hffff, -32768, -32768));
        send_frame(frame_of(1, 0, 517, 16'h0001, 12345, -12345));
        send_frame(frame_of(0, 0, 515, 4096, 200, 9));
        send_frame(frame_of(0, 0, 516, 8191, -200, 9));
        send_frame(frame_of(0, 0, 516, 1, 77, 9));
        drain();

        random_run();

        set_config(0, 63, 32'h00ffffff, 0, 32'hffffffff, 0);
        random_run();

        set_config(2047, 0, 0, 32'h00ffffff, 0, 32'hffffffff);
        random_run();

        set_config(2042, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_run();

        set_config((32'($urandom_range(0, 31)) << ID_W) | 32'($urandom_range(0, 2041)),
                   $urandom, $urandom, $urandom, $urandom, $urandom);
        random_run();

        set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_run();

        set_config(32'(RST_ID_BASE), 32'(RST_TYPE_MASK), 32'(RST_POS_SCALE_A),
                   32'(RST_POS_SCALE_B), RST_SPEED_SCALE_A, RST_SPEED_SCALE_B);
        random_run();

        if (sb.errors == 0 && sb.pending_feedback.size() == 0) begin
            $display("PASS geared_motor_feedback_tracker");
        end else begin
            $display("FAIL geared_motor_feedback_tracker");
        end
        $finish;
    end
endmodule
